// File: rtl/dfdl_pkg.sv
`timescale 1ns / 1ps

package dfdl_pkg;

    // coefficient and sample format
    localparam int Q_ONE  = 32768;
    localparam int Q_HALF = 16384;

    localparam int DEFAULT_DEPTH = 65536;

    // configuration register map
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY    = 2'd0,
        REG_FEEDBACK = 2'd1,
        REG_DAMPING  = 2'd2
    } t_cfg_reg;

    localparam logic [15:0] RST_DELAY    = 16'd12000;
    localparam logic [15:0] RST_FEEDBACK = 16'd16384;
    localparam logic [15:0] RST_DAMPING  = 16'd16384;

    // full-precision product and rounding accumulator
    typedef logic signed [33:0] t_prod;
    typedef logic signed [34:0] t_acc;

    // coefficients above one saturate to one
    function automatic logic [16:0] clamp_coeff(input logic [15:0] c);
        logic [16:0] r;
        if ({1'b0, c} > 17'(Q_ONE)) begin
            r = 17'(Q_ONE);
        end else begin
            r = {1'b0, c};
        end
        return r;
    endfunction

    // floor((p + half) / one), kept at 20 bits
    function automatic logic signed [19:0] round_q15(input t_acc p);
        t_acc s;
        s = p + 35'(Q_HALF);
        return s[34:15];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/damped_feedback_delay_line.sv
// damped feedback delay line, signed q1.15 audio samples
//
// sample request channel: i_valid / o_ready / i_sample_in
// result request channel: o_valid / i_ready / o_sample_out, one result per sample
// config channel: i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data,
//   index 0 delay, 1 feedback gain, 2 damping; other indexes are dropped.
//   o_cfg_ready is always high; write only while the block is idle.
//
// a sample is taken only in the idle state; o_valid rises as the block
// returns to idle, when the next sample can be taken, so a new sample is
// taken only once the last is written back. the rate is set by the chain
// buffer read -> lowpass multiply -> round -> feedback multiply -> write-back,
// which ends in the single write port of the sample buffer.
// when the receiver stalls, the finished result waits in the output
// register and the write-back step holds until that register is free.
// reset (synchronous, active low) zeroes write position and lowpass state
// and reloads register defaults; buffer entries not yet written since reset
// read as zero by a fill flag, so no clearing pass is needed.
`timescale 1ns / 1ps

module damped_feedback_delay_line #(
    parameter int BUFFER_DEPTH = dfdl_pkg::DEFAULT_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample in
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [15:0]             i_sample_in,
    // sample out
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [15:0]             o_sample_out,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dfdl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    import dfdl_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    // width wide enough for both the delay register and the depth
    localparam int CW = (AW + 1 > 16) ? AW + 1 : 16;
    localparam logic [CW-1:0] DLY_MAX = CW'(BUFFER_DEPTH - 2);
    localparam logic [AW-1:0] WP_LAST = AW'(BUFFER_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MIX,
        S_FB,
        S_WB
    } t_state;

    // configuration registers
    logic [15:0] r_delay;
    logic [15:0] r_feedback;
    logic [15:0] r_damping;

    // control
    t_state         r_state;
    logic [AW-1:0]  r_wp;
    logic           r_wrapped;
    logic           r_ovalid;
    logic signed [15:0] r_out;

    // datapath
    logic signed [15:0] r_x;
    logic signed [15:0] r_rd;
    logic signed [15:0] r_lp;
    logic               r_rd_ok;
    t_prod              r_p1;
    t_prod              r_p2;
    t_prod              r_p3;

    // sample buffer, one write and one registered read port
    logic signed [15:0] r_mem [BUFFER_DEPTH];
    logic signed [15:0] r_mem_q;

    logic               accept;
    logic               wb_go;
    logic [CW-1:0]      dly_ext;
    logic [AW-1:0]      dly;
    logic [AW:0]        rp_wrap;
    logic [AW-1:0]      rp;
    logic               rp_ok;
    logic [16:0]        coef_d;
    logic [16:0]        coef_g;
    logic signed [17:0] coef_1md_s;
    logic signed [17:0] coef_d_s;
    logic signed [17:0] coef_g_s;
    logic signed [15:0] rd;
    t_prod              n_p1;
    t_prod              n_p2;
    t_prod              n_p3;
    logic signed [15:0] n_lp;
    logic signed [19:0] fb;
    logic signed [15:0] n_wdata;
    logic [AW-1:0]      n_wp;

    assign o_ready      = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_ovalid;
    assign o_sample_out = r_out;

    assign accept = i_valid && o_ready;
    // write-back waits while an earlier result is still held
    assign wb_go  = (r_state == S_WB) && (!r_ovalid || i_ready);

    // read address: delay clamped to 1..depth-2, then wrapped behind wp
    always_comb begin
        dly_ext = CW'(r_delay);
        if (dly_ext > DLY_MAX) begin
            dly_ext = DLY_MAX;
        end
        if (dly_ext == '0) begin
            dly_ext = CW'(1);
        end
        dly = dly_ext[AW-1:0];
        if (r_wp >= dly) begin
            rp_wrap = {1'b0, r_wp} - {1'b0, dly};
        end else begin
            rp_wrap = {1'b0, r_wp} + (AW+1)'(BUFFER_DEPTH) - {1'b0, dly};
        end
        rp = rp_wrap[AW-1:0];
        // entries below wp, or any entry after the first wrap, hold written data
        rp_ok = r_wrapped || (rp < r_wp);
    end

    // coefficients
    always_comb begin
        coef_d     = clamp_coeff(r_damping);
        coef_g     = clamp_coeff(r_feedback);
        coef_1md_s = $signed({1'b0, 17'(Q_ONE) - coef_d});
        coef_d_s   = $signed({1'b0, coef_d});
        coef_g_s   = $signed({1'b0, coef_g});
    end

    // lowpass and feedback arithmetic
    always_comb begin
        rd      = r_rd_ok ? r_mem_q : 16'sd0;
        n_p1    = rd * coef_1md_s;
        n_p2    = r_lp * coef_d_s;
        n_lp    = sat16(round_q15(t_acc'(r_p1) + t_acc'(r_p2)));
        n_p3    = r_lp * coef_g_s;
        fb      = round_q15(t_acc'(r_p3));
        n_wdata = sat16(20'(r_x) + fb);
        n_wp    = (r_wp == WP_LAST) ? '0 : r_wp + AW'(1);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay    <= RST_DELAY;
            r_feedback <= RST_FEEDBACK;
            r_damping  <= RST_DAMPING;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DELAY:    r_delay    <= i_cfg_data;
                REG_FEEDBACK: r_feedback <= i_cfg_data;
                REG_DAMPING:  r_damping  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // sample buffer
    always_ff @(posedge i_clk) begin
        if (wb_go) begin
            r_mem[r_wp] <= n_wdata;
        end
        r_mem_q <= r_mem[rp];
    end

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_lp      <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            // a new result loaded in the same cycle keeps valid high
            if (r_ovalid && i_ready && !wb_go) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_x     <= i_sample_in;
                        r_rd_ok <= rp_ok;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rd    <= rd;
                    r_p1    <= n_p1;
                    r_p2    <= n_p2;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_lp    <= n_lp;
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_p3    <= n_p3;
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (wb_go) begin
                        r_wp     <= n_wp;
                        if (r_wp == WP_LAST) begin
                            r_wrapped <= 1'b1;
                        end
                        r_out    <= r_rd;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a result appears only out of the write-back step
    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_WB))
        else $error("result raised outside write-back");

    // a taken sample always starts the multiply step
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_MUL))
        else $error("taken sample did not start processing");

    // write position moves only on a buffer write
    a_wp_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_wp) |-> $past(wb_go))
        else $error("write position moved without a write");

    // the fill flag is cleared only by reset
    a_wrap_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_wrapped))
        else $error("fill flag cleared outside reset");

    // never read the entry being written in the same step
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (rp != r_wp))
        else $error("read address equals write position");
`endif

endmodule
